// ===== hw/rtl/multiline_reply_line_parser_assert.svh =====
// Assertion macros used by the reply line parser core.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef MULTILINE_REPLY_LINE_PARSER_ASSERT_SVH
`define MULTILINE_REPLY_LINE_PARSER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define MRLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define MRLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mrlp_pkg.sv =====
// Package for the reply line parser: result kinds, line classes, characters
// and the word types passed between the stages. No dependencies.
`default_nettype none

package mrlp_pkg;

    // Result kinds reported on the output stream.
    typedef enum logic [3:0] {
        K_RPAY     = 4'd0,
        K_BPAY     = 4'd1,
        K_REND     = 4'd2,
        K_BEND     = 4'd3,
        K_SHORT    = 4'd4,
        K_MISMATCH = 4'd5,
        K_UNSOL    = 4'd6,
        K_REFUSED  = 4'd7,
        K_ACCEPTED = 4'd8
    } kind_t;

    // Class a line is given at its first character.
    typedef enum logic [1:0] {
        CLS_REPLY = 2'd0,
        CLS_BCAST = 2'd1,
        CLS_UNSOL = 2'd2,
        CLS_DROP  = 2'd3
    } line_class_t;

    // Input action codes.
    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_BYTE    = 1'b1;

    // Characters of interest.
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_BCAST = 8'h36;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;

    // Position at which the code and continuation mark are complete.
    localparam logic [2:0] POS_MARK = 3'd3;
    localparam logic [2:0] POS_BODY = 3'd4;

    // One input word.
    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } item_t;

    // One result word.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [23:0] reply_code;
        logic        final_res;
        logic        success;
    } result_t;

    // Result word with its valid flag, from the parser core to the output stage.
    typedef struct packed {
        logic    valid;
        result_t res;
    } result_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/multiline_reply_line_parser.sv =====
// Reply line parser for a text protocol with a three-character code per line.
// A word moves from the input register through the parser core into the result
// register; the input register accepts a new word every cycle as long as the
// result register is free or being read. Throughput is one word per cycle under
// that condition, and each result is registered in the result register; both follow
// from the single input register and single result register around the parser logic.
// Words that cause no result (code characters, the fourth character unless its
// code check fails, body characters of unsolicited or discarded lines, and the
// newline of a discarded line) are consumed silently.
// Depends on mrlp_pkg, mrlp_in_stage, mrlp_core and mrlp_out_stage.
`default_nettype none

module multiline_reply_line_parser
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tuser,   // [0] action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [7:0] data_byte, [31:8] reply_code,
                                             // [32] final_res, [33] success, rest zero
    output logic [3:0]       m_axis_tuser    // [3:0] kind
);
    import mrlp_pkg::*;

    item_t        in_item;
    item_t        item;
    logic         item_valid;
    logic         advance;
    logic         out_free;
    result_word_t result;
    result_t      out_res;

    assign in_item.action  = s_axis_tuser;
    assign in_item.rx_byte = s_axis_tdata;

    // A word leaves the input register whenever the result register can take it.
    assign advance = item_valid && out_free;

    mrlp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mrlp_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item),
        .result  (result)
    );

    mrlp_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .free      (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Pack the result word onto the master stream.
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {6'd0, out_res.success, out_res.final_res,
                           out_res.reply_code, out_res.data_byte};

endmodule

`default_nettype wire

// ===== hw/rtl/mrlp_in_stage.sv =====
// Input register of the reply line parser.
// Depends on mrlp_pkg for the input word type.
`default_nettype none

module mrlp_in_stage
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire mrlp_pkg::item_t in_item,
    input  wire logic          advance,
    output logic               item_valid,
    output mrlp_pkg::item_t    item
);
    import mrlp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // The register takes a new word when empty or when its word moves on.
    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mrlp_core.sv =====
// Parser core: reply and line state, and the per-character decision logic.
// Depends on mrlp_pkg and on the assertion macro header.
`default_nettype none
`include "multiline_reply_line_parser_assert.svh"

module mrlp_core
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_en,
    input  wire mrlp_pkg::item_t item,
    output mrlp_pkg::result_word_t result
);
    import mrlp_pkg::*;

    logic        reply_open_reg,    reply_open_next;
    logic        code_known_reg,    code_known_next;
    logic [23:0] expected_code_reg, expected_code_next;
    logic [23:0] line_code_reg,     line_code_next;
    logic [2:0]  line_position_reg, line_position_next;
    line_class_t line_class_reg,    line_class_next;
    logic        code_differs_reg,  code_differs_next;
    logic        more_follows_reg,  more_follows_next;

    logic [7:0]  c;
    logic [7:0]  first_char;

    assign c          = item.rx_byte;
    assign first_char = line_code_reg[23:16];

    // Decide the next state and the result for the word in the input register.
    always_comb
    begin
        reply_open_next    = reply_open_reg;
        code_known_next    = code_known_reg;
        expected_code_next = expected_code_reg;
        line_code_next     = line_code_reg;
        line_position_next = line_position_reg;
        line_class_next    = line_class_reg;
        code_differs_next  = code_differs_reg;
        more_follows_next  = more_follows_reg;

        result.valid          = 1'b0;
        result.res.kind       = K_RPAY;
        result.res.data_byte  = '0;
        result.res.reply_code = '0;
        result.res.final_res  = 1'b0;
        result.res.success    = 1'b0;

        if (item.action == ACT_COMMAND)
        begin
            // A command opens a reply unless one is already open.
            result.valid = 1'b1;
            if (reply_open_reg)
            begin
                result.res.kind = K_REFUSED;
            end
            else
            begin
                result.res.kind    = K_ACCEPTED;
                reply_open_next    = 1'b1;
                code_known_next    = 1'b0;
                expected_code_next = '0;
            end
        end
        else if (c == CH_NL)
        begin
            // Line end: report by class, then start a fresh line.
            result.res.reply_code = line_code_reg;
            if (line_class_reg == CLS_DROP)
            begin
                result.valid = 1'b0;
            end
            else if (line_position_reg < POS_BODY)
            begin
                result.valid    = 1'b1;
                result.res.kind = K_SHORT;
                reply_open_next = 1'b0;
            end
            else
            begin
                result.valid = 1'b1;
                case (line_class_reg)
                    CLS_REPLY:
                    begin
                        result.res.kind      = K_REND;
                        result.res.final_res = !more_follows_reg;
                        result.res.success   = (first_char == CH_TWO) ||
                                               (first_char == CH_THREE);
                        reply_open_next      = more_follows_reg;
                    end
                    CLS_BCAST:
                    begin
                        result.res.kind = K_BEND;
                    end
                    default:
                    begin
                        result.res.kind = K_UNSOL;
                    end
                endcase
            end
            line_code_next     = '0;
            line_position_next = '0;
            line_class_next    = CLS_REPLY;
            code_differs_next  = 1'b0;
            more_follows_next  = 1'b0;
        end
        else if (line_position_reg < POS_MARK)
        begin
            // Code characters: classify on the first, collect all three.
            if (line_position_reg == 3'd0)
            begin
                if (c == CH_BCAST)
                begin
                    line_class_next = CLS_BCAST;
                end
                else if (reply_open_reg)
                begin
                    line_class_next = CLS_REPLY;
                end
                else
                begin
                    line_class_next = CLS_UNSOL;
                end
            end
            case (line_position_reg)
                3'd0:    line_code_next[23:16] = c;
                3'd1:    line_code_next[15:8]  = c;
                default: line_code_next[7:0]   = c;
            endcase
            line_position_next = line_position_reg + 3'd1;
        end
        else if (line_position_reg == POS_MARK)
        begin
            // Fourth character: check the code, note a continuation mark.
            line_position_next = POS_BODY;
            more_follows_next  = (c == CH_DASH);
            if (line_class_reg == CLS_REPLY)
            begin
                if (code_known_reg && (line_code_reg != expected_code_reg))
                begin
                    code_differs_next     = 1'b1;
                    reply_open_next       = 1'b0;
                    line_class_next       = CLS_DROP;
                    more_follows_next     = more_follows_reg;
                    result.valid          = 1'b1;
                    result.res.kind       = K_MISMATCH;
                    result.res.reply_code = line_code_reg;
                end
                else if (!code_known_reg)
                begin
                    expected_code_next = line_code_reg;
                    code_known_next    = 1'b1;
                end
            end
        end
        else
        begin
            // Body characters are passed on for reply and broadcast lines.
            result.res.data_byte  = c;
            result.res.reply_code = line_code_reg;
            if (line_class_reg == CLS_REPLY)
            begin
                result.valid    = 1'b1;
                result.res.kind = K_RPAY;
            end
            else if (line_class_reg == CLS_BCAST)
            begin
                result.valid    = 1'b1;
                result.res.kind = K_BPAY;
            end
        end

        if (!step_en)
        begin
            result.valid = 1'b0;
        end
    end

    // State registers advance once per word taken from the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_open_reg    <= 1'b0;
            code_known_reg    <= 1'b0;
            expected_code_reg <= '0;
            line_code_reg     <= '0;
            line_position_reg <= '0;
            line_class_reg    <= CLS_REPLY;
            code_differs_reg  <= 1'b0;
            more_follows_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            reply_open_reg    <= reply_open_next;
            code_known_reg    <= code_known_next;
            expected_code_reg <= expected_code_next;
            line_code_reg     <= line_code_next;
            line_position_reg <= line_position_next;
            line_class_reg    <= line_class_next;
            code_differs_reg  <= code_differs_next;
            more_follows_reg  <= more_follows_next;
        end
    end

    // A discarded line is always one that failed the code check.
    `MRLP_ASSERT_NOW(a_drop_means_differs, line_class_reg == CLS_DROP, code_differs_reg, "discarded line without code mismatch")
    // The continuation mark is only known once the fourth character is in.
    `MRLP_ASSERT_NOW(a_mark_after_fourth, more_follows_reg, line_position_reg == POS_BODY, "continuation flag before fourth character")
    // Every command word yields a result.
    `MRLP_ASSERT_NOW(a_command_answered, step_en && (item.action == ACT_COMMAND), result.valid, "command without result")
    // An accepted command leaves a reply open with no code yet.
    `MRLP_ASSERT_NEXT(a_accept_opens, step_en && (item.action == ACT_COMMAND) && !reply_open_reg, reply_open_reg && !code_known_reg, "accepted command did not open reply")

endmodule

`default_nettype wire

// ===== hw/rtl/mrlp_out_stage.sv =====
// Result register of the reply line parser, feeding the master stream.
// Depends on mrlp_pkg for the result word types.
`default_nettype none

module mrlp_out_stage
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire mrlp_pkg::result_word_t result,
    output logic                        free,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output mrlp_pkg::result_t           out_res
);
    import mrlp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // The register can take a word when empty or when its word is taken now.
    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load && result.valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (free && load && result.valid)
        begin
            res_reg <= result.res;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/multiline_reply_line_parser_tb.sv =====
// Self-checking testbench for the reply line parser: streams commands and received
// characters in, predicts every result word and checks it field by field.
// Depends on mrlp_pkg and multiline_reply_line_parser.
module multiline_reply_line_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mrlp_pkg::*;

    localparam int RANDOM_WORDS = 850;
    localparam int CYCLE_LIMIT  = 300000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        s_axis_tuser = 1'b0;    // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [7:0] data_byte, [31:8] reply_code,
                                         // [32] final_res, [33] success
    logic [3:0]  m_axis_tuser;           // [3:0] kind

    // Words waiting to be sent and result words the parser still owes.
    item_t   send_words[$];
    result_t parse_results_due[$];

    // Parser state as the prediction sees it.
    logic        reply_active = 1'b0;
    logic        code_locked = 1'b0;
    logic [23:0] locked_code = '0;
    logic [23:0] cur_code = '0;
    logic [2:0]  cur_pos = '0;
    line_class_t cur_class = CLS_REPLY;
    logic        cur_cont = 1'b0;

    int error_count = 0;
    int words_total = 0;
    int words_taken = 0;
    int commands_taken = 0;
    int results_checked = 0;
    int kind_seen [0:8];
    int cycle_count = 0;

    // Handshake bookkeeping for the sender and receiver.
    logic in_fire = 1'b0;
    int   burst_left = 1;
    int   gap_left = 0;
    logic steady = 1'b0;
    int   steady_left = 0;
    int   stall_mode = 0;
    int   stall_left = 0;
    int   stall_phase = 0;

    multiline_reply_line_parser dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // Count one failure and print it.
    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Work out what one accepted word produces and queue it.
    task automatic predict_word(input logic act, input logic [7:0] ch);
        result_t     r;
        logic [7:0]  lead;
        r = '0;
        if (act == ACT_COMMAND)
        begin
            if (reply_active)
            begin
                r.kind = K_REFUSED;
            end
            else
            begin
                reply_active = 1'b1;
                code_locked = 1'b0;
                locked_code = '0;
                r.kind = K_ACCEPTED;
            end
            parse_results_due.push_back(r);
        end
        else if (ch == CH_NL)
        begin
            // A line of a dropped class ends silently.
            if (cur_class != CLS_DROP)
            begin
                r.reply_code = cur_code;
                if (cur_pos < POS_BODY)
                begin
                    reply_active = 1'b0;
                    r.kind = K_SHORT;
                end
                else if (cur_class == CLS_REPLY)
                begin
                    lead = cur_code[23:16];
                    r.kind = K_REND;
                    r.final_res = !cur_cont;
                    r.success = (lead == CH_TWO) || (lead == CH_THREE);
                    reply_active = cur_cont;
                end
                else if (cur_class == CLS_BCAST)
                begin
                    r.kind = K_BEND;
                end
                else
                begin
                    r.kind = K_UNSOL;
                end
                parse_results_due.push_back(r);
            end
            cur_code = '0;
            cur_pos = '0;
            cur_class = CLS_REPLY;
            cur_cont = 1'b0;
        end
        else if (cur_pos < POS_MARK)
        begin
            // Code characters; the first one fixes the line class.
            if (cur_pos == 3'd0)
            begin
                if (ch == CH_BCAST)
                    cur_class = CLS_BCAST;
                else if (reply_active)
                    cur_class = CLS_REPLY;
                else
                    cur_class = CLS_UNSOL;
            end
            case (cur_pos)
                3'd0:    cur_code[23:16] = ch;
                3'd1:    cur_code[15:8] = ch;
                default: cur_code[7:0] = ch;
            endcase
            cur_pos = cur_pos + 3'd1;
        end
        else if (cur_pos == POS_MARK)
        begin
            // Fourth character: code check, then the continuation mark.
            cur_pos = POS_BODY;
            if (cur_class == CLS_REPLY && code_locked && cur_code != locked_code)
            begin
                reply_active = 1'b0;
                cur_class = CLS_DROP;
                r.kind = K_MISMATCH;
                r.reply_code = cur_code;
                parse_results_due.push_back(r);
            end
            else
            begin
                if (cur_class == CLS_REPLY && !code_locked)
                begin
                    locked_code = cur_code;
                    code_locked = 1'b1;
                end
                cur_cont = (ch == CH_DASH);
            end
        end
        else if (cur_class == CLS_REPLY || cur_class == CLS_BCAST)
        begin
            r.kind = (cur_class == CLS_REPLY) ? K_RPAY : K_BPAY;
            r.data_byte = ch;
            r.reply_code = cur_code;
            parse_results_due.push_back(r);
        end
    endtask

    // Stimulus helpers.
    task automatic put_word(input logic act, input logic [7:0] b);
        item_t w;
        w.action = act;
        w.rx_byte = b;
        send_words.push_back(w);
    endtask

    task automatic put_line(input logic [23:0] code, input logic [7:0] mark, input int body);
        logic [7:0] b;
        put_word(ACT_BYTE, code[23:16]);
        put_word(ACT_BYTE, code[15:8]);
        put_word(ACT_BYTE, code[7:0]);
        put_word(ACT_BYTE, mark);
        for (int i = 0; i < body; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_NL)
                b = 8'h20;
            put_word(ACT_BYTE, b);
        end
        put_word(ACT_BYTE, CH_NL);
    endtask

    function automatic logic [7:0] any_digit();
        return 8'($urandom_range(8'h30, 8'h39));
    endfunction

    // A command followed by a well-formed multiline reply, with stray broadcasts and commands.
    task automatic put_conversation();
        int          lines;
        logic [23:0] code;
        logic [7:0]  mark;
        put_word(ACT_COMMAND, 8'($urandom_range(0, 255)));
        code = {8'($urandom_range(8'h31, 8'h35)), any_digit(), any_digit()};
        lines = $urandom_range(1, 4);
        for (int k = 0; k < lines; k++)
        begin
            if ($urandom_range(0, 5) == 0)
                put_line({CH_BCAST, any_digit(), any_digit()}, 8'h20, $urandom_range(0, 4));
            if ($urandom_range(0, 9) == 0)
                put_word(ACT_COMMAND, 8'($urandom_range(0, 255)));
            if (k < lines - 1)
            begin
                mark = CH_DASH;
            end
            else
            begin
                mark = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h41, 8'h7A)) : 8'h20;
            end
            put_line(code, mark, $urandom_range(0, 6));
        end
    endtask

    // Broken or stray traffic.
    task automatic put_noise();
        int n;
        case ($urandom_range(0, 5))
            0:
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    put_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            1:
            begin
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                    put_word(ACT_BYTE, any_digit());
                put_word(ACT_BYTE, CH_NL);
            end
            2: put_line({8'($urandom_range(8'h31, 8'h35)), any_digit(), any_digit()},
                        CH_DASH, $urandom_range(0, 4));
            3: put_line({8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255))},
                        8'($urandom_range(0, 255)), $urandom_range(0, 5));
            4: put_line({CH_BCAST, any_digit(), any_digit()},
                        ($urandom_range(0, 1) != 0) ? CH_DASH : 8'h20, $urandom_range(0, 5));
            default: put_word(ACT_COMMAND, 8'($urandom_range(0, 255)));
        endcase
    endtask

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, parse_results_due.size());
            $display("multiline_reply_line_parser: mismatch");
            $finish;
        end
    end

    // Input side: take note of accepted words and predict their results.
    always @(posedge clk)
    begin
        in_fire = rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire)
        begin
            predict_word(send_words[0].action, send_words[0].rx_byte);
            if (send_words[0].action == ACT_COMMAND)
                commands_taken++;
            void'(send_words.pop_front());
            words_taken++;
        end
    end

    // Sender: bursts of words with random gaps, and stretches with no gaps.
    always @(negedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && !in_fire))
        begin
            if (steady_left == 0)
            begin
                steady = ($urandom_range(0, 3) == 0);
                steady_left = $urandom_range(50, 300);
            end
            else
            begin
                steady_left--;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (send_words.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= send_words[0].rx_byte;
                s_axis_tuser <= send_words[0].action;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = steady ? 0 : $urandom_range(0, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switches between always ready, light and heavy random stalls,
    // and a fixed two-in-eight pattern.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(40, 250);
            end
            else
            begin
                stall_left--;
            end
            stall_phase++;
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ((stall_phase % 8) < 2);
            endcase
        end
    end

    // Output side: compare every result word with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        result_t want;
        kind_t   got_kind;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_kind = kind_t'(m_axis_tuser);
            if (parse_results_due.size() == 0)
            begin
                report_error($sformatf("unexpected result kind %0d code %06h",
                                       m_axis_tuser, m_axis_tdata[31:8]));
            end
            else
            begin
                want = parse_results_due.pop_front();
                results_checked++;
                if (want.kind <= K_ACCEPTED)
                    kind_seen[want.kind]++;
                if (got_kind != want.kind)
                    report_error($sformatf("result %0d: kind %0d, predicted %0d",
                                           results_checked, got_kind, want.kind));
                if (m_axis_tdata[7:0] != want.data_byte)
                    report_error($sformatf("result %0d: data_byte %02h, predicted %02h",
                                           results_checked, m_axis_tdata[7:0], want.data_byte));
                if (m_axis_tdata[31:8] != want.reply_code)
                    report_error($sformatf("result %0d: reply_code %06h, predicted %06h",
                                           results_checked, m_axis_tdata[31:8],
                                           want.reply_code));
                if (m_axis_tdata[32] != want.final_res)
                    report_error($sformatf("result %0d: final_res %0b, predicted %0b",
                                           results_checked, m_axis_tdata[32], want.final_res));
                if (m_axis_tdata[33] != want.success)
                    report_error($sformatf("result %0d: success %0b, predicted %0b",
                                           results_checked, m_axis_tdata[33], want.success));
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        foreach (kind_seen[i])
            kind_seen[i] = 0;

        // Directed words: empty line, short stray line, accept and refuse,
        // a continued reply with an all-ones payload byte, a broadcast inside the
        // reply, a code mismatch, a command arriving in mid-line, and a reply line.
        put_word(ACT_BYTE, CH_NL);
        put_word(ACT_BYTE, 8'h31);
        put_word(ACT_BYTE, CH_NL);
        put_word(ACT_COMMAND, 8'h00);
        put_word(ACT_COMMAND, 8'hFF);
        put_word(ACT_BYTE, CH_TWO);
        put_word(ACT_BYTE, CH_THREE);
        put_word(ACT_BYTE, 8'h30);
        put_word(ACT_BYTE, CH_DASH);
        put_word(ACT_BYTE, 8'hFF);
        put_word(ACT_BYTE, CH_NL);
        put_line({CH_BCAST, 8'h30, 8'h30}, 8'h20, 1);
        put_word(ACT_BYTE, CH_TWO);
        put_word(ACT_BYTE, CH_THREE);
        put_word(ACT_BYTE, 8'h00);
        put_word(ACT_BYTE, 8'h20);
        put_word(ACT_BYTE, CH_NL);
        put_word(ACT_BYTE, 8'h35);
        put_word(ACT_BYTE, 8'h30);
        put_word(ACT_COMMAND, 8'h55);
        put_word(ACT_BYTE, 8'h30);
        put_word(ACT_BYTE, 8'h20);
        put_word(ACT_BYTE, CH_NL);
        put_line({CH_THREE, 8'h33, 8'h31}, 8'h20, 1);

        // Random part: mostly well-formed conversations, some noise.
        words_total = send_words.size() + RANDOM_WORDS;
        while (send_words.size() < words_total)
        begin
            if ($urandom_range(0, 9) < 7)
                put_conversation();
            else
                put_noise();
        end
        words_total = send_words.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (words_taken < words_total || parse_results_due.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("sent %0d words (%0d commands), checked %0d results", words_taken,
                 commands_taken, results_checked);
        $display("reply ends %0d, broadcast ends %0d, short %0d, code mismatches %0d, "
                 , kind_seen[K_REND], kind_seen[K_BEND], kind_seen[K_SHORT],
                 kind_seen[K_MISMATCH],
                 "unsolicited %0d, refused %0d", kind_seen[K_UNSOL], kind_seen[K_REFUSED]);
        if (error_count == 0)
        begin
            $display("multiline_reply_line_parser: match");
        end
        else
        begin
            $display("multiline_reply_line_parser: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mrlp_pkg.sv
hw/rtl/mrlp_in_stage.sv
hw/rtl/mrlp_core.sv
hw/rtl/mrlp_out_stage.sv
hw/rtl/multiline_reply_line_parser.sv
tb/sv/multiline_reply_line_parser_tb.sv
